// ===== rtl/dfq_pkg.sv =====
// shared types and constants for the dedup fifo queue
// used by dfq_ctrl, dfq_datapath and dedup_fifo_queue; depends on nothing
package dfq_pkg;

	// queue geometry
	localparam int DEPTH     = 16;
	localparam int ITEM_BITS = 32;
	localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS  = $clog2(DEPTH + 1);

	// fixed field widths of the beats
	localparam int IN_ITEM_BITS  = 32;
	localparam int OUT_ITEM_BITS = 32;
	localparam int MATCH_BITS    = 4;
	localparam int OCC_BITS      = 5;

	// stream bus widths
	localparam int S_DATA_BITS = 32;
	localparam int S_USER_BITS = 1;
	localparam int M_DATA_BITS = 48;
	localparam int M_USER_BITS = 3;

	// request kinds
	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_DUP   = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_EMPTY = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;     // capture the incoming request
		logic execute;  // compare, update the queue, load the result
	} ctl_cmd_t;

endpackage

// ===== rtl/dfq_ctrl.sv =====
// controller state machine of the dedup fifo queue
// depends on dfq_pkg; drives the datapath through ctl_cmd_t
module dfq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output dfq_pkg::ctl_cmd_t cmd
);
	import dfq_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		cmd.load    = 1'b0;
		cmd.execute = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				// room for a result once the pending one leaves
				s_tready = !out_valid_q || m_tready;
				if (s_tvalid && s_tready) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.execute = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output beat holding flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.execute) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

// ===== rtl/dfq_datapath.sv =====
// datapath of the dedup fifo queue: request register, entry store,
// parallel compare, count and result register; depends on dfq_pkg
module dfq_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dfq_pkg::ctl_cmd_t                   cmd,
	input  logic                                mode,
	input  logic [dfq_pkg::IN_ITEM_BITS-1:0]    item,
	output logic [dfq_pkg::OUT_ITEM_BITS-1:0]   out_item,
	output logic                                out_valid,
	output dfq_pkg::status_t                    status,
	output logic [dfq_pkg::MATCH_BITS-1:0]      match_index,
	output logic [dfq_pkg::OCC_BITS-1:0]        occupancy
);
	import dfq_pkg::*;

	logic                  req_mode_q;
	logic [ITEM_BITS-1:0]  req_item_q;
	logic [ITEM_BITS-1:0]  entries_q [DEPTH];
	logic [CNT_BITS-1:0]   count_q;
	logic [CNT_BITS-1:0]   count_d;

	logic                  found;
	logic [MATCH_BITS-1:0] match_d;
	logic                  is_full;
	logic                  is_empty;
	logic                  do_push;
	logic                  do_pop;
	status_t               status_d;

	logic [OUT_ITEM_BITS-1:0] res_item_q;
	logic                     res_valid_q;
	status_t                  res_status_q;
	logic [MATCH_BITS-1:0]    res_match_q;
	logic [OCC_BITS-1:0]      res_occ_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_mode_q <= mode;
			req_item_q <= ITEM_BITS'(item);
		end
	end

	// compare against every live entry, lowest position wins
	always_comb begin
		found   = 1'b0;
		match_d = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if ((CNT_BITS'(i) < count_q) && (entries_q[i] == req_item_q)) begin
				found   = 1'b1;
				match_d = MATCH_BITS'(i);
			end
		end
	end

	assign is_full  = (count_q == CNT_BITS'(DEPTH));
	assign is_empty = (count_q == '0);

	always_comb begin
		do_push  = 1'b0;
		do_pop   = 1'b0;
		status_d = STAT_DONE;
		count_d  = count_q;
		if (req_mode_q == MODE_ENQ) begin
			priority if (found) begin
				status_d = STAT_DUP;
			end else if (is_full) begin
				status_d = STAT_FULL;
			end else begin
				do_push = 1'b1;
				count_d = count_q + 1'b1;
			end
		end else begin
			if (is_empty) begin
				status_d = STAT_EMPTY;
			end else begin
				do_pop  = 1'b1;
				count_d = count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.execute) begin
			count_q <= count_d;
		end
	end

	// entry store: append at the tail, shift toward the head on a pop
	always_ff @(posedge clk) begin
		if (cmd.execute && do_push) begin
			entries_q[count_q[IDX_BITS-1:0]] <= req_item_q;
		end else if (cmd.execute && do_pop) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				entries_q[i] <= entries_q[i + 1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			res_item_q   <= do_pop ? OUT_ITEM_BITS'(entries_q[0]) : '0;
			res_valid_q  <= do_pop;
			res_status_q <= status_d;
			res_match_q  <= found && (req_mode_q == MODE_ENQ) ? match_d : '0;
			res_occ_q    <= OCC_BITS'(count_d);
		end
	end

	assign out_item    = res_item_q;
	assign out_valid   = res_valid_q;
	assign status      = res_status_q;
	assign match_index = res_match_q;
	assign occupancy   = res_occ_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(DEPTH))
		else $error("count beyond depth");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.execute |=> $stable(count_q))
		else $error("count moved without execute");

	a_pop_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute && (req_mode_q == MODE_DEQ) && !is_empty
		|=> count_q == $past(count_q) - 1'b1)
		else $error("dequeue did not lower count by one");
`endif

endmodule

// ===== rtl/dedup_fifo_queue.sv =====
// top level of the dedup fifo queue: stream ports, field packing
// depends on dfq_pkg, dfq_ctrl and dfq_datapath

// A first-in first-out queue of up to DEPTH items (16) that never holds two
// equal items. Each input beat carries a request: an enqueue (tuser 0)
// compares its item against every stored entry at once and either reports a
// duplicate with the matching position, reports a full queue, or appends the
// item; a dequeue (tuser 1) returns the oldest item and moves the rest one
// place toward the head, or reports an empty queue. Every request produces
// exactly one output beat, which also reports the occupancy after the step.
// The request is first captured in the request register; the parallel
// compare and queue update then load the output register. No new request
// is taken while one is in its update step; while a result waits in the
// output register unread, s_tready stays low.
module dedup_fifo_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	// request side
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [dfq_pkg::S_DATA_BITS-1:0] s_tdata,  // [31:0] item
	input  logic [dfq_pkg::S_USER_BITS-1:0] s_tuser,  // [0] mode
	// result side
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [dfq_pkg::M_DATA_BITS-1:0] m_tdata,  // [31:0] out_item, [35:32] match_index,
	                                                  // [40:36] occupancy, [47:41] zero
	output logic [dfq_pkg::M_USER_BITS-1:0] m_tuser   // [0] out_valid, [2:1] status
);
	import dfq_pkg::*;

	ctl_cmd_t                 cmd;
	logic [OUT_ITEM_BITS-1:0] out_item;
	logic                     out_valid;
	status_t                  status;
	logic [MATCH_BITS-1:0]    match_index;
	logic [OCC_BITS-1:0]      occupancy;

	// handshake sequencing and output beat holding
	dfq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// entry store, compare and result register
	dfq_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.mode        (s_tuser[0]),
		.item        (s_tdata[IN_ITEM_BITS-1:0]),
		.out_item    (out_item),
		.out_valid   (out_valid),
		.status      (status),
		.match_index (match_index),
		.occupancy   (occupancy)
	);

	// pack result fields, lowest field first, zero fill to whole bytes
	assign m_tdata = M_DATA_BITS'({occupancy, match_index, out_item});
	assign m_tuser = M_USER_BITS'({status, out_valid});

endmodule
